[rtl/b64e_pkg.sv]
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, constants and the alphabet lookup for the base64 encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

    localparam int unsigned GROUP_FIFO_DEPTH = 2;

    localparam logic [6:0] PAD_CHAR    = 7'd61;   // '='
    localparam logic [5:0] ALPHA_COUNT = 6'd26;
    localparam logic [6:0] CHAR_UPPER_A = 7'd65;  // 'A'
    localparam logic [6:0] CHAR_LOWER_A = 7'd97;  // 'a'
    localparam logic [6:0] CHAR_DIGIT_0 = 7'd48;  // '0'
    localparam logic [6:0] CHAR_PLUS    = 7'd43;  // '+'
    localparam logic [6:0] CHAR_SLASH   = 7'd47;  // '/'

    // one 24-bit group waiting to be turned into four characters
    typedef struct packed {
        logic [23:0] bits;
        logic [1:0]  pad_count;  // trailing '=' characters: 0, 1 or 2
        logic        last;       // last character of the group ends the message
    } t_group;

    function automatic logic [6:0] sextet_char(input logic [5:0] idx);
        logic [6:0] ch;
        if (idx < ALPHA_COUNT) begin
            ch = CHAR_UPPER_A + {1'b0, idx};
        end else if (idx < 6'd52) begin
            ch = CHAR_LOWER_A + {1'b0, idx} - {1'b0, ALPHA_COUNT};
        end else if (idx < 6'd62) begin
            ch = CHAR_DIGIT_0 + {1'b0, idx} - 7'd52;
        end else if (idx == 6'd62) begin
            ch = CHAR_PLUS;
        end else begin
            ch = CHAR_SLASH;
        end
        return ch;
    endfunction

endpackage

[rtl/b64e_if.sv]
// ----------------------------------------------------------------------------
// b64e_if
// Valid/ready channels of the base64 encoder: message bytes in, characters out.
// ----------------------------------------------------------------------------
interface b64e_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_message;

    modport source (output valid, output data_byte, output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface b64e_char_if;
    logic       valid;
    logic       ready;
    logic [6:0] code_char;
    logic       last_char;

    modport source (output valid, output code_char, output last_char, input ready);
    modport sink   (input valid, input code_char, input last_char, output ready);
endinterface

[rtl/b64e_front.sv]
// ----------------------------------------------------------------------------
// b64e_front
// Collects message bytes into 24-bit groups and pushes each finished group.
// ----------------------------------------------------------------------------
module b64e_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    b64e_byte_if.sink        i_byte,
    input  logic             i_q_ready,
    output logic             o_push,
    output b64e_pkg::t_group o_group
);
    import b64e_pkg::*;

    logic [15:0] r_hold;
    logic [15:0] n_hold;
    logic [1:0]  r_cnt;
    logic [1:0]  n_cnt;
    logic        accept;

    assign i_byte.ready = i_q_ready;
    assign accept       = i_byte.valid && i_q_ready;

    always_comb begin
        n_hold            = r_hold;
        n_cnt             = r_cnt;
        o_push            = 1'b0;
        o_group.bits      = {r_hold, i_byte.data_byte};
        o_group.pad_count = 2'd0;
        o_group.last      = i_byte.end_of_message;
        if (accept) begin
            case (r_cnt)
                2'd0: begin
                    if (i_byte.end_of_message) begin
                        o_push            = 1'b1;
                        o_group.bits      = {i_byte.data_byte, 16'h0000};
                        o_group.pad_count = 2'd2;
                    end else begin
                        n_hold[15:8] = i_byte.data_byte;
                        n_cnt        = 2'd1;
                    end
                end
                2'd1: begin
                    if (i_byte.end_of_message) begin
                        o_push            = 1'b1;
                        o_group.bits      = {r_hold[15:8], i_byte.data_byte, 8'h00};
                        o_group.pad_count = 2'd1;
                        n_cnt             = 2'd0;
                    end else begin
                        n_hold[7:0] = i_byte.data_byte;
                        n_cnt       = 2'd2;
                    end
                end
                default: begin
                    // third byte closes the group
                    o_push = 1'b1;
                    n_cnt  = 2'd0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 2'd0;
            r_hold <= 16'h0000;
        end else begin
            r_cnt  <= n_cnt;
            r_hold <= n_hold;
        end
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("pending byte count out of range");
`endif

endmodule

[rtl/b64e_queue.sv]
// ----------------------------------------------------------------------------
// b64e_queue
// Short group queue between byte collection and character output.
// ----------------------------------------------------------------------------
module b64e_queue #(
    parameter int unsigned DEPTH = b64e_pkg::GROUP_FIFO_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  b64e_pkg::t_group i_wdata,
    output logic             o_ready,
    output logic             o_valid,
    output b64e_pkg::t_group o_rdata,
    input  logic             i_pop
);
    import b64e_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_group           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_ready = (r_count != CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_rdata = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_ready)
        else $error("group pushed into full queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("group popped from empty queue");
`endif

endmodule

[rtl/b64e_back.sv]
// ----------------------------------------------------------------------------
// b64e_back
// Turns each queued group into four characters, one per output transfer.
// ----------------------------------------------------------------------------
module b64e_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  b64e_pkg::t_group i_group,
    output logic             o_pop,
    b64e_char_if.source      o_char
);
    import b64e_pkg::*;

    logic [1:0] r_pos;
    logic       r_valid;
    logic [6:0] r_char;
    logic       r_last;
    logic       load;
    logic [5:0] sextet;
    logic       is_pad;
    logic [6:0] n_char;

    assign load  = i_q_valid && (!r_valid || o_char.ready);
    assign o_pop = load && (r_pos == 2'd3);

    always_comb begin
        case (r_pos)
            2'd0:    sextet = i_group.bits[23:18];
            2'd1:    sextet = i_group.bits[17:12];
            2'd2:    sextet = i_group.bits[11:6];
            default: sextet = i_group.bits[5:0];
        endcase
        is_pad = ({1'b0, r_pos} + {1'b0, i_group.pad_count}) > 3'd3;
        n_char = is_pad ? PAD_CHAR : sextet_char(sextet);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pos   <= 2'd0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_pos   <= r_pos + 2'd1;
        end else if (o_char.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_char <= n_char;
            r_last <= (r_pos == 2'd3) && i_group.last;
        end
    end

    assign o_char.valid     = r_valid;
    assign o_char.code_char = r_char;
    assign o_char.last_char = r_last;

`ifndef SYNTHESIS
    a_pop_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_pos == 2'd0))
        else $error("character position not restarted after group");
    a_last_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && i_group.last && (r_pos == 2'd3)) |=> (r_last && r_valid))
        else $error("message end not flagged on final character");
`endif

endmodule

[rtl/base64_encoder_top.sv]
// ----------------------------------------------------------------------------
// base64_encoder_top
// Base64 encoder, standard alphabet with padding, one byte in, one char out.
// ----------------------------------------------------------------------------
//  channel  dir  payload                           transfer
//  i_byte   in   data_byte[7:0], end_of_message    valid && ready
//  o_char   out  code_char[6:0], last_char         valid && ready
//
//  A byte is taken in the cycle it is offered while the group queue has room.
//  Each closed group leaves as four characters, one per cycle while o_char is
//  ready, from the output register; the single-character output port sets the
//  sustained rate. The first character of a group passes through the queue and
//  the output register. Reset clears pending bytes, queue and output.
//  A stall on o_char holds the output register and fills the queue, then
//  drops i_byte.ready.
module base64_encoder_top #(
    parameter int unsigned GROUP_FIFO_DEPTH = b64e_pkg::GROUP_FIFO_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    b64e_byte_if.sink   i_byte,
    b64e_char_if.source o_char
);
    import b64e_pkg::*;

    logic   push;
    logic   q_ready;
    logic   q_valid;
    logic   pop;
    t_group push_group;
    t_group head_group;

    b64e_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte    (i_byte),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_group   (push_group)
    );

    b64e_queue #(
        .DEPTH (GROUP_FIFO_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (push_group),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_rdata (head_group),
        .i_pop   (pop)
    );

    b64e_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_group   (head_group),
        .o_pop     (pop),
        .o_char    (o_char)
    );

endmodule
